@@ sv/dqzrc_pkg.sv @@
// Shared types and constants of the delta-quantising zero-run coder.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package dqzrc_pkg;

  // Field widths of the channels and the configuration port.
  localparam int SAMPLE_W    = 8;
  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;
  localparam int STEP_W      = 8;
  localparam int RECIP_W     = 9;

  // Predictor and arithmetic widths.
  localparam int PRED_W  = 10;
  localparam int DIFF_W  = 11;
  localparam int PROD_W  = 21;
  localparam int QRAW_W  = PROD_W - 8;
  localparam int PRED_MAX = 511;
  localparam int PRED_MIN = -512;

  // Zero-run coding constants.
  localparam int RUN_W          = 9;
  localparam int RUN_LIMIT      = 256;
  localparam int RUN_FLUSH_SYM  = 255;
  localparam int RUN_ONE_SYM    = 1;
  localparam int RUN_MARK_SYM   = 0;

  // At most this many bytes leave the block per quad.
  localparam int MAX_RESULTS = 13;
  localparam int BYTE_IDX_W  = $clog2(MAX_RESULTS + 1);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_QUANT_STEP  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUANT_RECIP = 1'b1;
  localparam logic [STEP_W-1:0]      QUANT_STEP_RESET  = 8'd9;
  localparam logic [RECIP_W-1:0]     QUANT_RECIP_RESET = 9'd28;

  // The six values of a quad, in coding order.
  typedef enum logic [2:0] {
    VAL_TL = 3'd0,
    VAL_TR = 3'd1,
    VAL_BL = 3'd2,
    VAL_BR = 3'd3,
    VAL_U  = 3'd4,
    VAL_V  = 3'd5
  } value_sel_t;

  // One input quad as held inside the block.
  typedef struct packed {
    logic [SAMPLE_W-1:0] luma_top_left;
    logic [SAMPLE_W-1:0] luma_top_right;
    logic [SAMPLE_W-1:0] luma_bottom_left;
    logic [SAMPLE_W-1:0] luma_bottom_right;
    logic [SAMPLE_W-1:0] chroma_u;
    logic [SAMPLE_W-1:0] chroma_v;
    logic                row_start;
    logic                frame_end;
  } quad_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       mul;
    logic       upd;
    logic       code_val;
    logic       code_term;
    logic       push;
    logic       drain;
    logic       pad;
    logic       term_phase;
    value_sel_t vsel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic queue_empty;
    logic has_byte;
    logic byte_go;
    logic pad_go;
    logic frame_end;
  } dp_status_t;

endpackage

@@ sv/dqzrc_quad_if.sv @@
// Input channel of the coder: one 2x2 luma quad with its chroma samples.
// Depends on dqzrc_pkg for the field widths.
interface dqzrc_quad_if;
  import dqzrc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] luma_top_left;
  logic [SAMPLE_W-1:0] luma_top_right;
  logic [SAMPLE_W-1:0] luma_bottom_left;
  logic [SAMPLE_W-1:0] luma_bottom_right;
  logic [SAMPLE_W-1:0] chroma_u;
  logic [SAMPLE_W-1:0] chroma_v;
  logic                row_start;
  logic                frame_end;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    output chroma_u, chroma_v, row_start, frame_end,
    input  ready
  );

  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    input  chroma_u, chroma_v, row_start, frame_end,
    output ready
  );

endinterface

@@ sv/dqzrc_byte_if.sv @@
// Output channel of the coder: one byte of the packed bitstream per transaction.
// Depends on dqzrc_pkg for the field widths.
interface dqzrc_byte_if;
  import dqzrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);

endinterface

@@ sv/dqzrc_ctrl.sv @@
// Controller state machine of the coder: sequences the six values of a quad,
// the symbol pushes, the byte drain and the frame-end flush. Depends on dqzrc_pkg.
module dqzrc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dqzrc_pkg::dp_status_t status,
  output dqzrc_pkg::dp_cmd_t    cmd
);
  import dqzrc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_UPD   = 7'b0000100,
    S_CODE  = 7'b0001000,
    S_PUSH  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_PAD   = 7'b1000000
  } state_t;

  state_t     state;
  state_t     state_next;
  value_sel_t vsel;
  value_sel_t vsel_next;
  logic       term;
  logic       term_next;

  // Following value in coding order.
  function automatic value_sel_t next_value(value_sel_t v);
    value_sel_t r;
    unique case (v)
      VAL_TL:  r = VAL_TR;
      VAL_TR:  r = VAL_BL;
      VAL_BL:  r = VAL_BR;
      VAL_BR:  r = VAL_U;
      VAL_U:   r = VAL_V;
      default: r = VAL_TL;
    endcase
    return r;
  endfunction

  // No transaction is taken while reset is held.
  assign in_ready = (state == S_IDLE) && !rst;

  // Next state and command decode.
  always_comb begin
    state_next     = state;
    vsel_next      = vsel;
    term_next      = term;
    cmd            = '0;
    cmd.vsel       = vsel;
    cmd.term_phase = term;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          vsel_next   = VAL_TL;
          term_next   = 1'b0;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_CODE;
      end
      S_CODE: begin
        cmd.code_val = 1'b1;
        state_next   = S_DRAIN;
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        priority if (status.has_byte) begin
          cmd.drain = status.byte_go;
        end else if (!status.queue_empty) begin
          state_next = S_PUSH;
        end else if (!term && vsel != VAL_V) begin
          vsel_next  = next_value(vsel);
          state_next = S_MUL;
        end else if (!term && status.frame_end) begin
          cmd.code_term = 1'b1;
          term_next     = 1'b1;
        end else if (term) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PAD: begin
        if (status.pad_go) begin
          cmd.pad    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vsel  <= VAL_TL;
      term  <= 1'b0;
    end else begin
      state <= state_next;
      vsel  <= vsel_next;
      term  <= term_next;
    end
  end

endmodule

@@ sv/dqzrc_datapath.sv @@
// Datapath of the coder: configuration registers, predictors, the two
// multiply steps, the symbol queue, the bit packer and the output register.
// Depends on dqzrc_pkg and dqzrc_byte_if.
module dqzrc_datapath #(
  parameter int SYMBOL_BITS = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dqzrc_pkg::quad_t                  quad_data,
  input  logic                              cfg_we,
  input  logic [dqzrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dqzrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  dqzrc_pkg::dp_cmd_t                cmd,
  output dqzrc_pkg::dp_status_t             status,
  dqzrc_byte_if.source                      stream
);
  import dqzrc_pkg::*;

  localparam int WinW   = SYMBOL_BITS + 7;
  localparam int CntW   = $clog2(SYMBOL_BITS + 8);
  localparam int QLimit = 2 ** (SYMBOL_BITS - 1) - 1;
  localparam int StepPW = SYMBOL_BITS + STEP_W + 1;
  localparam logic signed [31:0] QLimPos = 32'(QLimit);
  localparam logic signed [31:0] QLimNeg = -32'(QLimit);
  localparam logic signed [31:0] PredHi  = 32'(PRED_MAX);
  localparam logic signed [31:0] PredLo  = 32'(PRED_MIN);

  // Configuration registers.
  logic [STEP_W-1:0]  quant_step;
  logic [RECIP_W-1:0] quant_recip;

  // Item and arithmetic state.
  quad_t                    quad_reg;
  logic signed [PRED_W-1:0] pred_top;
  logic signed [PRED_W-1:0] pred_bot;
  logic signed [PRED_W-1:0] pred_u;
  logic signed [PRED_W-1:0] pred_v;
  logic signed [PROD_W-1:0] prod;
  logic signed [SYMBOL_BITS-1:0] q_val;

  // Coding state.
  logic [RUN_W-1:0]       zero_run;
  logic [SYMBOL_BITS-1:0] sym_q [3];
  logic [1:0]             sym_n;
  logic [WinW-1:0]        window;
  logic [CntW-1:0]        bit_cnt;
  logic [BYTE_IDX_W-1:0]  byte_idx;

  // Output register.
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  // Combinational signals.
  logic [SAMPLE_W-1:0]        sample;
  logic signed [PRED_W-1:0]   pred_cur;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_full;
  logic signed [QRAW_W-1:0]   q_raw;
  logic signed [31:0]         q_wide;
  logic signed [31:0]         q_clip;
  logic signed [SYMBOL_BITS-1:0] q_sat;
  logic signed [StepPW-1:0]   step_prod;
  logic signed [31:0]         np_wide;
  logic signed [31:0]         np_clip;
  logic signed [PRED_W-1:0]   pred_new;
  logic signed [SYMBOL_BITS-1:0] q_neg;
  logic [SYMBOL_BITS-1:0]     val_sym;
  logic [SYMBOL_BITS-1:0]     run_sym;
  logic [RUN_W-1:0]           run_inc;
  logic                       drop;
  logic                       out_free;
  logic                       out_load;
  logic                       drain_last;
  logic                       pad_emit;

  // Select the sample and predictor of the current value.
  always_comb begin
    unique case (cmd.vsel)
      VAL_TL: begin sample = quad_reg.luma_top_left;     pred_cur = pred_top; end
      VAL_TR: begin sample = quad_reg.luma_top_right;    pred_cur = pred_top; end
      VAL_BL: begin sample = quad_reg.luma_bottom_left;  pred_cur = pred_bot; end
      VAL_BR: begin sample = quad_reg.luma_bottom_right; pred_cur = pred_bot; end
      VAL_U:  begin sample = quad_reg.chroma_u;          pred_cur = pred_u;   end
      VAL_V:  begin sample = quad_reg.chroma_v;          pred_cur = pred_v;   end
      default: begin sample = quad_reg.chroma_v;         pred_cur = pred_v;   end
    endcase
  end

  // First multiply: prediction error times the reciprocal.
  assign diff      = $signed({3'b000, sample}) - DIFF_W'(pred_cur);
  assign prod_full = diff * $signed({1'b0, quant_recip});

  // Floor division by 256, clip to the code range, then advance the predictor.
  assign q_raw = prod[PROD_W-1:8];
  assign q_wide = 32'(q_raw);
  always_comb begin
    priority if (q_wide > QLimPos) q_clip = QLimPos;
    else if (q_wide < QLimNeg)     q_clip = QLimNeg;
    else                           q_clip = q_wide;
  end
  assign q_sat     = q_clip[SYMBOL_BITS-1:0];
  assign step_prod = q_sat * $signed({1'b0, quant_step});
  assign np_wide   = 32'(pred_cur) + 32'(step_prod);
  always_comb begin
    priority if (np_wide > PredHi) np_clip = PredHi;
    else if (np_wide < PredLo)     np_clip = PredLo;
    else                           np_clip = np_wide;
  end
  assign pred_new = np_clip[PRED_W-1:0];

  // Zigzag code plus one of a nonzero value, and the run symbol.
  assign q_neg   = -q_val;
  assign val_sym = q_val[SYMBOL_BITS-1] ? {q_neg[SYMBOL_BITS-2:0], 1'b0}
                                        : {q_val[SYMBOL_BITS-2:0], 1'b1};
  assign run_sym = SYMBOL_BITS'(zero_run);
  assign run_inc = zero_run + RUN_W'(1);

  // Byte emission control.
  assign drop       = (byte_idx >= BYTE_IDX_W'(MAX_RESULTS));
  assign out_free   = !out_valid || stream.ready;
  assign pad_emit   = (bit_cnt != '0) && !drop;
  assign out_load   = (cmd.drain && !drop) || (cmd.pad && pad_emit);
  assign drain_last = quad_reg.frame_end &&
                      ((byte_idx == BYTE_IDX_W'(MAX_RESULTS - 1)) ||
                       (cmd.term_phase && sym_n == 2'd0 && bit_cnt == CntW'(8)));

  // Status to the controller.
  always_comb begin
    status.queue_empty = (sym_n == 2'd0);
    status.has_byte    = (bit_cnt >= CntW'(8));
    status.byte_go     = out_free || drop;
    status.pad_go      = (bit_cnt == '0) || out_free || drop;
    status.frame_end   = quad_reg.frame_end;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      quant_step  <= QUANT_STEP_RESET;
      quant_recip <= QUANT_RECIP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUANT_STEP:  quant_step  <= cfg_data[STEP_W-1:0];
        CFG_QUANT_RECIP: quant_recip <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers of the item and the arithmetic steps.
  always_ff @(posedge clk) begin
    if (cmd.load_in) quad_reg <= quad_data;
    if (cmd.mul)     prod     <= prod_full;
    if (cmd.upd)     q_val    <= q_sat;
  end

  // Predictors: cleared at the start of a row, advanced after each value.
  always_ff @(posedge clk) begin
    if (rst) begin
      pred_top <= '0;
      pred_bot <= '0;
      pred_u   <= '0;
      pred_v   <= '0;
    end else if (cmd.load_in && quad_data.row_start) begin
      pred_top <= '0;
      pred_bot <= '0;
      pred_u   <= '0;
      pred_v   <= '0;
    end else if (cmd.upd) begin
      unique case (cmd.vsel)
        VAL_TL, VAL_TR: pred_top <= pred_new;
        VAL_BL, VAL_BR: pred_bot <= pred_new;
        VAL_U:          pred_u   <= pred_new;
        VAL_V:          pred_v   <= pred_new;
        default: ;
      endcase
    end
  end

  // Symbol contents of the queue.
  always_ff @(posedge clk) begin
    if (cmd.code_val) begin
      if (q_val == '0) begin
        sym_q[0] <= SYMBOL_BITS'(RUN_MARK_SYM);
        sym_q[1] <= SYMBOL_BITS'(RUN_FLUSH_SYM);
      end else if (zero_run > RUN_W'(1)) begin
        sym_q[0] <= SYMBOL_BITS'(RUN_MARK_SYM);
        sym_q[1] <= run_sym;
        sym_q[2] <= val_sym;
      end else if (zero_run == RUN_W'(1)) begin
        sym_q[0] <= SYMBOL_BITS'(RUN_ONE_SYM);
        sym_q[1] <= val_sym;
      end else begin
        sym_q[0] <= val_sym;
      end
    end else if (cmd.code_term) begin
      sym_q[0] <= SYMBOL_BITS'(RUN_MARK_SYM);
      sym_q[1] <= SYMBOL_BITS'(RUN_MARK_SYM);
    end else if (cmd.push) begin
      sym_q[0] <= sym_q[1];
      sym_q[1] <= sym_q[2];
    end
  end

  // Queue fill, zero run, bit window and byte count.
  always_ff @(posedge clk) begin
    if (rst) begin
      sym_n    <= 2'd0;
      zero_run <= '0;
      window   <= '0;
      bit_cnt  <= '0;
      byte_idx <= '0;
    end else begin
      if (cmd.load_in) byte_idx <= '0;
      if (cmd.code_val) begin
        if (q_val == '0) begin
          if (run_inc == RUN_W'(RUN_LIMIT)) begin
            sym_n    <= 2'd2;
            zero_run <= RUN_W'(1);
          end else begin
            zero_run <= run_inc;
          end
        end else begin
          zero_run <= '0;
          if (zero_run > RUN_W'(1))       sym_n <= 2'd3;
          else if (zero_run == RUN_W'(1)) sym_n <= 2'd2;
          else                            sym_n <= 2'd1;
        end
      end
      if (cmd.code_term) sym_n <= 2'd2;
      if (cmd.push) begin
        window  <= window | (WinW'(sym_q[0]) << bit_cnt[2:0]);
        bit_cnt <= bit_cnt + CntW'(SYMBOL_BITS);
        sym_n   <= sym_n - 2'd1;
      end
      if (cmd.drain) begin
        window  <= window >> 8;
        bit_cnt <= bit_cnt - CntW'(8);
        if (!drop) byte_idx <= byte_idx + BYTE_IDX_W'(1);
      end
      if (cmd.pad) begin
        window   <= '0;
        bit_cnt  <= '0;
        zero_run <= '0;
        if (pad_emit) byte_idx <= byte_idx + BYTE_IDX_W'(1);
      end
    end
  end

  // Output register: holds a byte until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= window[BYTE_W-1:0];
      out_last <= cmd.pad ? 1'b1 : drain_last;
    end
  end

  assign stream.valid    = out_valid;
  assign stream.out_byte = out_byte;
  assign stream.last     = out_last;

endmodule

@@ sv/delta_quant_zero_run_coder.sv @@
// Lossy DPCM encoder with zero-run coding for YUV 4:2:0 quads. Each quad is
// worked on alone: the block takes one, then returns to accept the next once
// its bytes are handed to the output register. Each value takes a multiply, a
// predictor update, a coding step and a decision; each symbol is pushed into
// the bit packer and its full bytes drained, and at frame end two more symbols
// are pushed and any partial byte padded out. The packer moves one byte per
// cycle to the output register, so a stalled sink holds the sequencer.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle; the block does not enforce this.
// Depends on dqzrc_pkg, both channel interfaces, dqzrc_ctrl and dqzrc_datapath.
module delta_quant_zero_run_coder #(
  parameter int SYMBOL_BITS = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  dqzrc_quad_if.sink                        quad,
  dqzrc_byte_if.source                      stream,
  input  logic                              cfg_we,
  input  logic [dqzrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dqzrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dqzrc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  quad_t      quad_data;
  logic       in_ready;

  // Gather the input payload into one word.
  always_comb begin
    quad_data.luma_top_left     = quad.luma_top_left;
    quad_data.luma_top_right    = quad.luma_top_right;
    quad_data.luma_bottom_left  = quad.luma_bottom_left;
    quad_data.luma_bottom_right = quad.luma_bottom_right;
    quad_data.chroma_u          = quad.chroma_u;
    quad_data.chroma_v          = quad.chroma_v;
    quad_data.row_start         = quad.row_start;
    quad_data.frame_end         = quad.frame_end;
  end

  assign quad.ready = in_ready;

  // Sequencer.
  dqzrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (quad.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic, coding and packing.
  dqzrc_datapath #(
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .quad_data (quad_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .stream    (stream)
  );

endmodule
